>>> hw/rtl/ppg_pkg.sv
// Shared types and constants for the packed pixel gray converter.
// No dependencies; every other file of the block imports this package.
package ppg_pkg;

    localparam int BYTE_BITS   = 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int IN_TDATA_W  = 16;

    // Register index, taken from paddr word address bits
    typedef enum logic [1:0] {
        REG_WIDTH_CODE    = 2'd0,
        REG_OUTPUT_FORMAT = 2'd1,
        REG_THRESHOLD     = 2'd2
    } reg_idx_t;

    typedef enum logic {
        FMT_GRAY8 = 1'b0,
        FMT_GRAY1 = 1'b1
    } fmt_t;

    typedef struct packed {
        logic [1:0] width_code;
        fmt_t       output_format;
        logic [7:0] threshold;
    } cfg_t;

    // One classified source word waiting for the back end
    typedef struct packed {
        logic [7:0] src_byte;
        logic [3:0] pix_count;
        logic       frame_end;
    } entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] fill;
        logic              not_empty;
        logic              full;
    } queue_status_t;

    typedef struct packed {
        logic [2:0] pack_count;
        logic [2:0] pix_idx;
        logic       item_done;
        logic       item_fend;
    } back_status_t;

endpackage

>>> hw/rtl/packed_pixel_gray_convert_top.sv
// Top level of the packed pixel gray converter: configuration registers,
// front end, queue and back end. Depends on ppg_pkg, ppg_front, ppg_queue, ppg_back.
//
// Each source word carries one packed byte of 1, 2, 4 or 8 bit pixels (MSB
// first) plus the number of pixels that belong to the frame; that count is
// saturated to what the byte holds. In gray8 mode each pixel leaves as one
// word, shifted up to the top of the byte. In gray1 mode each pixel is
// compared with the threshold and the bits are packed MSB first; a word
// leaves after every eight pixels and a partial byte is dropped at frame end.
// tlast on the output marks the final word caused by one source word.
// Rate: the back end handles one pixel per cycle while the output register
// is free or m_tready is high, and a source word with no pixels still takes a
// step. A two-entry queue lets the next source word be taken while the back
// end works; the back end stalls while a word in the output register waits
// for m_tready. Write configuration only while the block is idle.
module packed_pixel_gray_convert_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ppg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // source words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ppg_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] src_byte, [11:8] pixels_valid
    input  logic                            s_tlast,   // frame_end
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast    // last_of_run
);
    import ppg_pkg::*;

    logic [1:0]    width_code_reg, width_code_next;
    fmt_t          fmt_reg, fmt_next;
    logic [7:0]    thresh_reg, thresh_next;
    cfg_t          cfg;
    reg_idx_t      reg_idx;
    logic          cfg_wr;

    entry_t        front_entry;
    entry_t        head;
    queue_status_t q_st;
    back_status_t  bk_st;
    logic          push;
    logic          pop;

    // Configuration registers; out-of-range addresses are ignored
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        width_code_next = width_code_reg;
        fmt_next        = fmt_reg;
        thresh_next     = thresh_reg;
        prdata          = '0;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WIDTH_CODE:    width_code_next = pwdata[1:0];
                REG_OUTPUT_FORMAT: fmt_next        = fmt_t'(pwdata[0]);
                REG_THRESHOLD:     thresh_next     = pwdata[7:0];
                default:           ;
            endcase
        end
        unique case (reg_idx)
            REG_WIDTH_CODE:    prdata = {30'd0, width_code_reg};
            REG_OUTPUT_FORMAT: prdata = {31'd0, fmt_reg};
            REG_THRESHOLD:     prdata = {24'd0, thresh_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_code_reg <= 2'd0;
            fmt_reg        <= FMT_GRAY8;
            thresh_reg     <= 8'd0;
        end
        else
        begin
            width_code_reg <= width_code_next;
            fmt_reg        <= fmt_next;
            thresh_reg     <= thresh_next;
        end
    end

    assign cfg.width_code    = width_code_reg;
    assign cfg.output_format = fmt_reg;
    assign cfg.threshold     = thresh_reg;

    // Accept a source word whenever the queue has room
    assign s_tready = !q_st.full;
    assign push     = s_tvalid && s_tready;

    ppg_front u_front (
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cfg     (cfg),
        .entry   (front_entry)
    );

    ppg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_st)
    );

    ppg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (q_st.not_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .status     (bk_st)
    );

    // Queue never holds more entries than it has slots
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_st.fill <= QCNT_W'(QDEPTH))
        else $error("queue fill above depth");

    // Frame end leaves the packing state cleared
    a_frame_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bk_st.item_done && bk_st.item_fend |=> bk_st.pack_count == 3'd0)
        else $error("packing state not cleared at frame end");

    // Pixel index stays inside the head entry's pixel count
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_st.not_empty && (head.pix_count != 4'd0) |->
            ({1'b0, bk_st.pix_idx} < head.pix_count))
        else $error("pixel index beyond pixel count");

endmodule

>>> hw/rtl/ppg_front.sv
// Front end: classify an incoming source word into a queue entry.
// Depends on ppg_pkg.
module ppg_front (
    input  logic [ppg_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] src_byte, [11:8] pixels_valid
    input  logic                           s_tlast,  // frame_end
    input  ppg_pkg::cfg_t                  cfg,
    output ppg_pkg::entry_t                entry
);
    import ppg_pkg::*;

    logic [3:0] per_byte;
    logic [3:0] valid_in;

    // Saturate the pixel count to what one byte holds at this width
    always_comb
    begin
        per_byte        = 4'd8 >> cfg.width_code;
        valid_in        = s_tdata[11:8];
        entry.src_byte  = s_tdata[7:0];
        entry.frame_end = s_tlast;
        entry.pix_count = (valid_in > per_byte) ? per_byte : valid_in;
    end

endmodule

>>> hw/rtl/ppg_queue.sv
// Short queue between front and back ends.
// Depends on ppg_pkg.
module ppg_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ppg_pkg::entry_t        push_entry,
    input  logic                   pop,
    output ppg_pkg::entry_t        head,
    output ppg_pkg::queue_status_t status
);
    import ppg_pkg::*;

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head             = mem_reg[rd_ptr_reg];
    assign status.fill      = fill_reg;
    assign status.not_empty = (fill_reg != '0);
    assign status.full      = (fill_reg == QCNT_W'(QDEPTH));

endmodule

>>> hw/rtl/ppg_back.sv
// Back end: walk head entry pixels, one per cycle when the output is free,
// into the output register. Holds gray1 packing state. Depends on ppg_pkg.
module ppg_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppg_pkg::cfg_t         cfg,
    input  logic                  head_valid,
    input  ppg_pkg::entry_t       head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // last_of_run
    output ppg_pkg::back_status_t status
);
    import ppg_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [7:0] acc_reg, acc_next;
    logic [2:0] pcnt_reg, pcnt_next;
    logic       mv_reg, mv_next;
    logic [7:0] mdata_reg, mdata_next;
    logic       mlast_reg, mlast_next;

    logic [3:0] bpp;
    logic [5:0] sh_wide;
    logic [7:0] shifted;
    logic [3:0] rsh_wide;
    logic [7:0] pix_val;
    logic [7:0] gray8_val;
    logic [7:0] acc_shift;
    logic       has_pix;
    logic       last_pix;
    logic       out_free;
    logic       step;

    always_comb
    begin
        bpp       = 4'd1 << cfg.width_code;
        sh_wide   = {3'b000, idx_reg} << cfg.width_code;
        shifted   = head.src_byte << sh_wide[2:0];
        rsh_wide  = 4'd8 - bpp;
        pix_val   = shifted >> rsh_wide[2:0];
        gray8_val = shifted & ~(8'hFF >> bpp);
        acc_shift = {acc_reg[6:0], (pix_val > cfg.threshold)};
        has_pix   = (head.pix_count != 4'd0);
        last_pix  = !has_pix || ({1'b0, idx_reg} == (head.pix_count - 4'd1));
        out_free  = !mv_reg || m_tready;
        step      = head_valid && out_free;
        pop       = step && last_pix;

        idx_next   = idx_reg;
        acc_next   = acc_reg;
        pcnt_next  = pcnt_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;

        if (step)
        begin
            idx_next = last_pix ? 3'd0 : idx_reg + 3'd1;
            if (has_pix)
            begin
                if (cfg.output_format == FMT_GRAY8)
                begin
                    mv_next    = 1'b1;
                    mdata_next = gray8_val;
                    mlast_next = last_pix;
                end
                else if (pcnt_reg == 3'd7)
                begin
                    // eighth bit: send the packed byte, restart packing
                    mv_next    = 1'b1;
                    mdata_next = acc_shift;
                    mlast_next = 1'b1;
                    acc_next   = 8'd0;
                    pcnt_next  = 3'd0;
                end
                else
                begin
                    acc_next  = acc_shift;
                    pcnt_next = pcnt_reg + 3'd1;
                end
            end
            // drop any partial byte at frame end
            if (last_pix && head.frame_end)
            begin
                acc_next  = 8'd0;
                pcnt_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 3'd0;
            acc_reg  <= 8'd0;
            pcnt_reg <= 3'd0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            acc_reg  <= acc_next;
            pcnt_reg <= pcnt_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid          = mv_reg;
    assign m_tdata           = mdata_reg;
    assign m_tlast           = mlast_reg;
    assign status.pack_count = pcnt_reg;
    assign status.pix_idx    = idx_reg;
    assign status.item_done  = pop;
    assign status.item_fend  = head.frame_end;

endmodule
